// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/ordct_pkg.sv =====
// ----------------------------------------------------------------------------
// ordct_pkg
// shared widths, constants and sequencer states of the order crossover block
// ----------------------------------------------------------------------------
package ordct_pkg;

	localparam int ID_W        = 10;
	localparam int ID_SPAN     = 1 << ID_W;
	localparam int LEN_W       = 24;
	localparam int OUT_TDATA_W = ((ID_W + LEN_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - LEN_W;
	// coordinates and lengths share these fraction bits, the root keeps them
	localparam int FRAC_BITS   = 4;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT,
		ST_ACCUM,
		ST_FINISH
	} ordct_state_t;

endpackage

// ===== hw/rtl/ordct_isqrt.sv =====
// ----------------------------------------------------------------------------
// ordct_isqrt
// iterative integer square root, rounded down, one root bit per cycle
// ----------------------------------------------------------------------------
module ordct_isqrt #(
	parameter int RAD_W = 27
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [RAD_W-1:0]         radicand,
	output logic                     busy,
	output logic                     done,
	output logic [(RAD_W+1)/2-1:0]   root
);

	localparam int ROOT_W = (RAD_W + 1) / 2;
	localparam int PAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int TRY_W  = REM_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [TRY_W-1:0]  trial;
	logic [TRY_W-1:0]  sub;
	logic [TRY_W-1:0]  diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, rad_q[PAD_W-1 -: 2]};
		sub   = {2'b00, root_q, 2'b01};
		diff  = trial - sub;
		ge    = trial >= sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= PAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[PAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/order_crossover_tour_length.sv =====
// ----------------------------------------------------------------------------
// order_crossover_tour_length
// Builds a child tour by one-point order crossover and sums its length.
// An item whose city is dropped or is the first kept city of a tour goes
// through accept, visited-map read and result; when a distance is added it
// also goes through the squaring, square root and accumulate states, and the
// square root unit produces one root bit per cycle. The result sits
// in an output register, so the next item is taken while it waits. After
// reset and after each item with tlast, a clearing pass writes the visited
// map one entry a cycle over min(MAX_CITIES, 1024) entries, during which no
// input is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module order_crossover_tour_length #(
	parameter int MAX_CITIES = 1024,
	parameter int COORD_BITS = 13,
	localparam int InTdataW  = ((ordct_pkg::ID_W + 2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [InTdataW-1:0]              s_tdata,  // city_id, x_pos, y_pos
	input  logic                             s_tuser,  // from_first
	input  logic                             s_tlast,  // last_city
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ordct_pkg::OUT_TDATA_W-1:0] m_tdata, // child_city, tour_length
	output logic                             m_tuser,  // kept
	output logic                             m_tlast   // tour_end
);

	import ordct_pkg::*;

	localparam int Depth  = (MAX_CITIES < ID_SPAN) ? MAX_CITIES : ID_SPAN;
	localparam int IdxW   = $clog2(Depth);
	localparam int RadW   = 2 * COORD_BITS + 1;
	localparam int RootW  = (RadW + 1) / 2;
	localparam int AccW   = ((LEN_W > RootW) ? LEN_W : RootW) + 1;

	ordct_state_t state_q, state_d;

	logic                  visit_mem_q [Depth];
	logic                  rd_bit_q;
	logic                  mem_we;
	logic                  mem_wdata;
	logic [IdxW-1:0]       mem_waddr;
	logic                  mem_re;
	logic [IdxW-1:0]       mem_raddr;

	logic [ID_W-1:0]       in_id;
	logic [COORD_BITS-1:0] in_x;
	logic [COORD_BITS-1:0] in_y;

	logic [ID_W-1:0]       id_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic                  first_q;
	logic                  last_q;
	logic                  keep_q;
	logic                  have_prev_q;
	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS-1:0] dy_q;
	logic [LEN_W-1:0]      len_q;
	logic [IdxW-1:0]       clr_addr_q;

	logic                  out_valid_q;
	logic                  out_kept_q;
	logic [ID_W-1:0]       out_city_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_end_q;

	logic                  accept;
	logic                  in_range;
	logic                  keep_now;
	logic                  clr_done;
	logic                  out_load;
	logic                  sqrt_start;
	logic                  sqrt_busy;
	logic                  sqrt_done;
	logic [RootW-1:0]      sqrt_root;
	logic [2*COORD_BITS-1:0] dx_sq;
	logic [2*COORD_BITS-1:0] dy_sq;
	logic [RadW-1:0]       radicand;
	logic [AccW-1:0]       acc_sum;
	logic [LEN_W-1:0]      len_next;

	assign in_id = s_tdata[ID_W-1:0];
	assign in_x  = s_tdata[ID_W +: COORD_BITS];
	assign in_y  = s_tdata[ID_W + COORD_BITS +: COORD_BITS];

	assign accept      = s_tvalid && s_tready;
	assign in_range    = 32'(id_q) < MAX_CITIES;
	assign keep_now    = in_range && (first_q || !rd_bit_q);
	assign clr_done    = clr_addr_q == IdxW'(Depth - 1);

	assign dx_sq    = dx_q * dx_q;
	assign dy_sq    = dy_q * dy_q;
	assign radicand = {1'b0, dx_sq} + {1'b0, dy_sq};

	assign acc_sum  = AccW'(len_q) + AccW'(sqrt_root);
	assign len_next = (acc_sum > AccW'(LEN_MAX)) ? LEN_MAX : acc_sum[LEN_W-1:0];

	ordct_isqrt #(
		.RAD_W (RadW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// visited map
	always_ff @(posedge clk) begin
		if (mem_we) begin
			visit_mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_bit_q <= visit_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		mem_we     = 1'b0;
		mem_wdata  = 1'b0;
		mem_waddr  = id_q[IdxW-1:0];
		mem_re     = 1'b0;
		mem_raddr  = in_id[IdxW-1:0];
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_re   = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_we    = keep_now;
				mem_wdata = 1'b1;
				state_d   = (keep_now && have_prev_q) ? ST_SQUARE : ST_FINISH;
			end
			ST_SQUARE: begin
				sqrt_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (sqrt_done) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = last_q ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			len_q       <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_done ? '0 : clr_addr_q + IdxW'(1);
			end
			if (state_q == ST_READ && keep_now) begin
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_ACCUM) begin
				len_q <= len_next;
			end
			if (out_load && last_q) begin
				have_prev_q <= 1'b0;
				len_q       <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= in_id;
			x_q     <= in_x;
			y_q     <= in_y;
			first_q <= s_tuser;
			last_q  <= s_tlast;
		end
		if (state_q == ST_READ) begin
			keep_q <= keep_now;
			dx_q   <= (x_q >= prev_x_q) ? x_q - prev_x_q : prev_x_q - x_q;
			dy_q   <= (y_q >= prev_y_q) ? y_q - prev_y_q : prev_y_q - y_q;
			if (keep_now) begin
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end
		end
		if (out_load) begin
			out_kept_q <= keep_q;
			out_city_q <= keep_q ? id_q : '0;
			out_len_q  <= len_q;
			out_end_q  <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_len_q, out_city_q};
	assign m_tuser  = out_kept_q;
	assign m_tlast  = out_end_q;

	`ASSERT_CLKD(a_root_start_idle, sqrt_start |-> !sqrt_busy, "root unit restarted while busy")
	`ASSERT_CLKD(a_root_done_wait, sqrt_done |-> (state_q == ST_ROOT), "root done outside wait")
	`ASSERT_NEXT(a_len_hold, !(state_q == ST_ACCUM || state_q == ST_FINISH), $stable(len_q), "length moved outside accumulate")
	`ASSERT_NEXT(a_len_grows, state_q == ST_ACCUM, len_q >= $past(len_q), "length decreased on accumulate")

endmodule

// ===== sim/order_crossover_tour_length_tb.sv =====
// ----------------------------------------------------------------------------
// order_crossover_tour_length_tb
// Self-checking bench for the order crossover tour length block. Streams
// child tours built from a first-parent prefix and a full second parent,
// plus malformed noise, with bursty input and a stalling output side. A
// local model of the visited map and the running length predicts every
// result, and each output transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module order_crossover_tour_length_tb;

	import ordct_pkg::*;

	localparam int COORD_W      = 13;
	localparam int MAX_CITIES   = 1024;
	localparam int IN_FIELDS_W  = ID_W + 2 * COORD_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam logic [COORD_W-1:0] COORD_TOP = '1;
	localparam int RANDOM_ITEMS = 660;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 64;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic [ID_W-1:0]    city_id;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic               from_first;
		logic               last_city;
	} city_item_t;

	typedef struct packed {
		logic             kept;
		logic [ID_W-1:0]  child_city;
		logic [LEN_W-1:0] tour_length;
		logic             tour_end;
	} tour_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;  // city_id, x_pos, y_pos
	logic                   s_tuser;  // from_first
	logic                   s_tlast;  // last_city
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // child_city, tour_length
	logic                   m_tuser;  // kept
	logic                   m_tlast;  // tour_end

	order_crossover_tour_length u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// model state of the child tour
	logic [MAX_CITIES-1:0] visited;
	logic                  have_prev;
	logic [COORD_W-1:0]    prev_x;
	logic [COORD_W-1:0]    prev_y;
	logic [LEN_W-1:0]      tour_sum;

	tour_result_t          expected_results [$];
	logic [COORD_W-1:0]    city_x [ID_SPAN];
	logic [COORD_W-1:0]    city_y [ID_SPAN];
	int                    error_count;
	int                    burst_left;
	bit                    sender_steady;
	bit                    hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic logic [13:0] floor_root(input logic [27:0] v);
		logic [13:0] root;
		logic [13:0] trial;
		root = '0;
		for (int b = 13; b >= 0; b--) begin
			trial = root | (14'd1 << b);
			if ({14'd0, trial} * {14'd0, trial} <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic tour_result_t advance_child_tour(input city_item_t it);
		tour_result_t r;
		logic         keep;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [27:0]  sq;
		logic [LEN_W:0] sum;
		keep = 1'b0;
		if (int'(it.city_id) < MAX_CITIES)
			keep = it.from_first || !visited[it.city_id];
		if (keep) begin
			visited[it.city_id] = 1'b1;
			if (have_prev) begin
				dx = (it.x_pos >= prev_x) ? it.x_pos - prev_x : prev_x - it.x_pos;
				dy = (it.y_pos >= prev_y) ? it.y_pos - prev_y : prev_y - it.y_pos;
				sq = dx * dx + dy * dy;
				sum = tour_sum + floor_root(sq);
				tour_sum = (sum > LEN_MAX) ? LEN_MAX : sum[LEN_W-1:0];
			end
			have_prev = 1'b1;
			prev_x = it.x_pos;
			prev_y = it.y_pos;
		end
		r.kept = keep;
		r.child_city = keep ? it.city_id : '0;
		r.tour_length = tour_sum;
		r.tour_end = it.last_city;
		if (it.last_city) begin
			visited = '0;
			have_prev = 1'b0;
			prev_x = '0;
			prev_y = '0;
			tour_sum = '0;
		end
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COORD_TOP;
			default: return COORD_W'($urandom_range(0, COORD_TOP));
		endcase
	endfunction

	task automatic send_city(input logic [ID_W-1:0] id, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic first, input logic last);
		city_item_t it;
		int gap;
		it = '{city_id: id, x_pos: x, y_pos: y, from_first: first, last_city: last};
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, y, x, id};
		s_tuser <= first;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.insert(expected_results.size(), advance_child_tour(it));
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 10);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic shuffle_ids(ref logic [ID_W-1:0] ids [$]);
		logic [ID_W-1:0] tmp;
		int k;
		for (int i = ids.size() - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = ids[i];
			ids[i] = ids[k];
			ids[k] = tmp;
		end
	endtask

	// well-formed tour: prefix of one permutation, then all of another
	task automatic send_tour(input int n, input int prefix_len);
		logic [ID_W-1:0]    pool [$];
		logic [ID_SPAN-1:0] taken;
		logic [ID_W-1:0]    pick;
		taken = '0;
		while (pool.size() < n) begin
			pick = ID_W'($urandom_range(0, ID_SPAN - 1));
			if (!taken[pick]) begin
				taken[pick] = 1'b1;
				pool.insert(pool.size(), pick);
				city_x[pick] = rand_coord();
				city_y[pick] = rand_coord();
			end
		end
		shuffle_ids(pool);
		for (int i = 0; i < prefix_len; i++)
			send_city(pool[i], city_x[pool[i]], city_y[pool[i]], 1'b1, 1'b0);
		shuffle_ids(pool);
		for (int i = 0; i < n; i++)
			send_city(pool[i], city_x[pool[i]], city_y[pool[i]], 1'b0, i == n - 1);
	endtask

	task automatic test_directed();
		// first kept city, extremes, repeated first-parent city, visited drops
		send_city(10'd0,    13'd0,     13'd0,     1'b1, 1'b0);
		send_city(10'd1023, COORD_TOP, COORD_TOP, 1'b1, 1'b0);
		send_city(10'd0,    COORD_TOP, 13'd0,     1'b1, 1'b0);
		send_city(10'd1023, 13'd100,   13'd200,   1'b0, 1'b0);
		send_city(10'd5,    13'd0,     COORD_TOP, 1'b0, 1'b0);
		send_city(10'd0,    13'd17,    13'd33,    1'b0, 1'b0);
		send_city(10'd682,  13'd2730,  13'd5461,  1'b0, 1'b0);
		send_city(10'd341,  13'd5461,  13'd2730,  1'b0, 1'b0);
		send_city(10'd1,    13'd0,     13'd0,     1'b0, 1'b1);
		// single-city tour
		send_city(10'd3,    COORD_TOP, COORD_TOP, 1'b1, 1'b1);
		// second parent only, tour ends on a dropped city
		send_city(10'd7,    13'd0,     13'd0,     1'b0, 1'b0);
		send_city(10'd9,    13'd3,     13'd4,     1'b0, 1'b0);
		send_city(10'd7,    13'd0,     13'd0,     1'b0, 1'b1);
		// after the clear the same city is kept again
		send_city(10'd7,    13'd1,     13'd1,     1'b0, 1'b0);
		send_city(10'd1023, 13'd8190,  13'd1,     1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		sender_steady = 1'b1;
		send_tour(24, 12);
		send_tour(16, 16);
		sender_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_tours();
		int sent;
		int n;
		int p;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sender_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 85) begin
				n = $urandom_range(2, 24);
				p = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) * n : $urandom_range(0, n);
				send_tour(n, p);
				sent += n + p;
			end else begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					send_city($urandom_range(0, 1) ? ID_W'($urandom_range(0, 15))
							: ID_W'($urandom_range(0, ID_SPAN - 1)),
						rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
						$urandom_range(0, 7) == 0);
				sent += n;
			end
		end
		sender_steady = 1'b0;
		wait_drained();
	endtask

	// output side stall pattern, with a long hold-off on request
	initial begin
		int mode;
		int stretch_left;
		mode = 0;
		stretch_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = $urandom_range(0, 3);
					stretch_left = $urandom_range(8, 80);
				end
				stretch_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= stretch_left[1];
				endcase
			end
		end
	end

	// result checker, one output transfer per edge
	initial begin
		tour_result_t exp_r;
		logic [ID_W-1:0]  got_city;
		logic [LEN_W-1:0] got_len;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got_city = m_tdata[ID_W-1:0];
				got_len = m_tdata[ID_W +: LEN_W];
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected transfer city %0d len %0d",
						got_city, got_len));
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tuser !== exp_r.kept)
						report_mismatch($sformatf("kept %b expected %b", m_tuser, exp_r.kept));
					if (got_city !== exp_r.child_city)
						report_mismatch($sformatf("child_city %0d expected %0d",
							got_city, exp_r.child_city));
					if (got_len !== exp_r.tour_length)
						report_mismatch($sformatf("tour_length %0d expected %0d",
							got_len, exp_r.tour_length));
					if (m_tlast !== exp_r.tour_end)
						report_mismatch($sformatf("tour_end %b expected %b",
							m_tlast, exp_r.tour_end));
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("order_crossover_tour_length_tb failed");
		$finish;
	end

	initial begin
		error_count = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		hold_request = 1'b0;
		visited = '0;
		have_prev = 1'b0;
		prev_x = '0;
		prev_y = '0;
		tour_sum = '0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random_tours();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0)
			$display("order_crossover_tour_length_tb passed");
		else
			$display("order_crossover_tour_length_tb failed");
		$finish;
	end

endmodule
